>>> rtl/sbsa_pkg.sv
package sbsa_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SEL_W   = 6;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned SPP_W   = 7;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned MAP_W   = 64;
  localparam int unsigned SLAB_D  = 64;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned META_W  = MAP_W + 2 * SPP_W;
  localparam int unsigned BASE_W  = 2 * ADDR_W;
  localparam int unsigned IN_DW   = 104;
  localparam int unsigned OUT_DW  = 128;

  localparam int unsigned MAX_SLABS_DEF      = 64;
  localparam int unsigned SLOTS_PER_SLAB_DEF = 64;
  localparam int unsigned PAGE_BYTES_DEF     = 4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_OBJ_BYTES = 3'd0,
    CFG_STRIDE    = 3'd1,
    CFG_SPP       = 3'd2,
    CFG_CAPACITY  = 3'd3,
    CFG_SLABS     = 3'd4
  } cfg_idx_e;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNALIGNED = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_DOUBLE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTPOOL   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LOOK,
    S_EVAL,
    S_DIVIDE,
    S_FREE_CHK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd;
    logic eval;
    logic div_start;
    logic free_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  skip;
    logic  hit;
    logic  last;
    logic  div_done;
    logic  out_free;
    logic  out_pending;
  } stat_t;

endpackage

>>> rtl/sbsa_ram.sv
module sbsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sbsa_div.sv
module sbsa_div #(
  parameter int unsigned NUM_W = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [NUM_W-1:0]               dividend_i,
  input  logic [sbsa_pkg::CFG_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [NUM_W-1:0]               quot_o,
  output logic [sbsa_pkg::CFG_W-1:0]     rem_o
);
  import sbsa_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   shifted;

  always_comb begin
    shifted = {rem_q, quot_q[NUM_W-1]};
    trial   = shifted - {1'b0, divisor_i};
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d  = trial[CFG_W-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[CFG_W-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/sbsa_ctrl.sv
module sbsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbsa_pkg::stat_t     stat_i,
  output sbsa_pkg::cmd_t      cmd_o
);
  import sbsa_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_START;
      S_START:    state_d = stat_i.skip ? S_RESULT : S_LOOK;
      S_LOOK:     state_d = S_EVAL;
      S_EVAL: begin
        if (stat_i.kind == KIND_LOAD) begin
          state_d = S_RESULT;
        end else if (stat_i.hit) begin
          state_d = (stat_i.kind == KIND_FREE) ? S_DIVIDE : S_RESULT;
        end else begin
          state_d = stat_i.last ? S_RESULT : S_LOOK;
        end
      end
      S_DIVIDE:   if (stat_i.div_done) state_d = S_FREE_CHK;
      S_FREE_CHK: state_d = S_RESULT;
      S_RESULT:   if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_LOOK:     cmd_o.rd = 1'b1;
      S_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.div_start = stat_i.hit && (stat_i.kind == KIND_FREE);
      end
      S_FREE_CHK: cmd_o.free_fin = 1'b1;
      S_RESULT:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> state_q == S_IDLE) else $error("capture outside idle");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> state_q == S_DIVIDE) else $error("divider done out of state");
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> stat_i.out_pending) else $error("result not held");

endmodule

>>> rtl/sbsa_dp.sv
module sbsa_dp #(
  parameter int unsigned MAX_SLABS      = sbsa_pkg::MAX_SLABS_DEF,
  parameter int unsigned SLOTS_PER_SLAB = sbsa_pkg::SLOTS_PER_SLAB_DEF,
  parameter int unsigned PAGE_BYTES     = sbsa_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbsa_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [sbsa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [sbsa_pkg::IN_DW-1:0]    in_data_i,
  input  logic [sbsa_pkg::KIND_W-1:0]   in_kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sbsa_pkg::OUT_DW-1:0]   out_data_o,
  output logic [sbsa_pkg::STAT_W-1:0]   out_status_o,
  input  sbsa_pkg::cmd_t                cmd_i,
  output sbsa_pkg::stat_t               stat_o
);
  import sbsa_pkg::*;

  localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
  localparam int unsigned QW      = (OFF_W > SPP_W) ? OFF_W : SPP_W;
  localparam int unsigned LIM_CAP = (MAX_SLABS < SLAB_D) ? MAX_SLABS : SLAB_D;
  localparam int unsigned SPP_CAP = (SLOTS_PER_SLAB < MAP_W) ? SLOTS_PER_SLAB : MAP_W;

  logic [CFG_W-1:0]  obj_q, stride_q, capacity_q;
  logic [SPP_W-1:0]  spp_q, slabs_q;

  kind_e             kind_q;
  logic [ADDR_W-1:0] addr_q, phys_q;
  logic [SEL_W-1:0]  sel_q, idx_q;
  logic [OFF_W-1:0]  off_q;
  logic [STAT_W-1:0] status_q;
  logic [ADDR_W-1:0] va_q, pa_q;
  logic [CFG_W-1:0]  granted_q;
  logic [CNT_W-1:0]  used_q;
  logic [SLAB_D-1:0] loaded_q;

  logic              out_valid_q;
  logic [OUT_DW-1:0] out_data_q;
  logic [STAT_W-1:0] out_status_q;

  logic              meta_we, base_we;
  logic [SEL_W-1:0]  raddr, waddr;
  logic [META_W-1:0] meta_rd, meta_wd;
  logic [BASE_W-1:0] base_rd;
  logic [MAP_W-1:0]  map_rd;
  logic [SPP_W-1:0]  slots_rd, free_rd;
  logic [ADDR_W-1:0] vbase_rd, pbase_rd;

  logic [SPP_W-1:0]  lim, spp;
  logic              sel_ok;
  logic              alloc_hit, free_match, hit;
  logic [ADDR_W-1:0] diff;
  logic [5:0]        low_idx;
  logic [18:0]       alloc_off;
  logic [CNT_W-1:0]  slot_base, cap_rem;
  logic [SPP_W-1:0]  cap;
  logic [MAP_W-1:0]  fill;
  logic [SPP_W-1:0]  held;

  logic              div_done;
  logic [OFF_W-1:0]  quot;
  logic [CFG_W-1:0]  rem;
  logic [OFF_W-1:0]  q_eff;
  logic              aligned, in_range, dbl;
  logic [STAT_W-1:0] free_status;

  function automatic logic [5:0] lowest_idx(input logic [MAP_W-1:0] v);
    logic [5:0] r;
    r = 6'd63;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  assign {slots_rd, free_rd, map_rd} = meta_rd;
  assign {pbase_rd, vbase_rd}        = base_rd;

  always_comb begin
    lim = (slabs_q > SPP_W'(LIM_CAP)) ? SPP_W'(LIM_CAP) : slabs_q;
    spp = (spp_q > SPP_W'(SPP_CAP)) ? SPP_W'(SPP_CAP) : spp_q;
    sel_ok = (32'(sel_q) < MAX_SLABS);
  end

  always_comb begin
    diff       = addr_q - vbase_rd;
    low_idx    = lowest_idx(map_rd);
    alloc_off  = 19'(low_idx) * 19'(stride_q);
    alloc_hit  = loaded_q[idx_q] && (free_rd != '0) && (map_rd != '0);
    free_match = loaded_q[idx_q] && (addr_q >= vbase_rd) && (diff < ADDR_W'(PAGE_BYTES));
    hit        = (kind_q == KIND_ALLOC) ? alloc_hit : free_match;
  end

  always_comb begin
    slot_base = CNT_W'(sel_q) * CNT_W'(spp);
    cap_rem   = capacity_q - slot_base;
    cap       = '0;
    if (capacity_q > slot_base) begin
      cap = (cap_rem < CNT_W'(spp)) ? cap_rem[SPP_W-1:0] : spp;
    end
    for (int j = 0; j < MAP_W; j++) begin
      fill[j] = (SPP_W'(j) < cap);
    end
    held = slots_rd - free_rd;
  end

  always_comb begin
    q_eff    = (stride_q == '0) ? '0 : quot;
    aligned  = (stride_q == '0) ? (off_q == '0) : (rem == '0);
    in_range = (QW'(q_eff) < QW'(slots_rd)) && (QW'(q_eff) < QW'(MAP_W));
    dbl      = map_rd[q_eff[5:0]];
    if (!aligned) begin
      free_status = ST_UNALIGNED;
    end else if (!in_range) begin
      free_status = ST_RANGE;
    end else if (dbl) begin
      free_status = ST_DOUBLE;
    end else begin
      free_status = ST_OK;
    end
  end

  always_comb begin
    raddr   = (kind_q == KIND_LOAD) ? sel_q : idx_q;
    waddr   = raddr;
    base_we = cmd_i.eval && (kind_q == KIND_LOAD);
    meta_we = 1'b0;
    meta_wd = {cap, cap, fill};
    if (base_we) begin
      meta_we = 1'b1;
    end else if (cmd_i.eval && (kind_q == KIND_ALLOC) && alloc_hit) begin
      meta_we = 1'b1;
      meta_wd = {slots_rd, free_rd - SPP_W'(1), map_rd & ~(MAP_W'(1) << low_idx)};
    end else if (cmd_i.free_fin && (free_status == ST_OK)) begin
      meta_we = 1'b1;
      meta_wd = {slots_rd, free_rd + SPP_W'(1), map_rd | (MAP_W'(1) << q_eff[5:0])};
    end
  end

  sbsa_ram #(.WIDTH(META_W), .DEPTH(SLAB_D)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wd),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (meta_rd)
  );

  sbsa_ram #(.WIDTH(BASE_W), .DEPTH(SLAB_D)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (waddr),
    .wdata_i ({phys_q, addr_q}),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (base_rd)
  );

  sbsa_div #(.NUM_W(OFF_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff[OFF_W-1:0]),
    .divisor_i  (stride_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_q       <= CFG_W'(1);
      stride_q    <= CFG_W'(64);
      spp_q       <= SPP_W'(64);
      capacity_q  <= CFG_W'(64);
      slabs_q     <= SPP_W'(1);
      kind_q      <= KIND_NOP;
      status_q    <= ST_OK;
      idx_q       <= '0;
      used_q      <= '0;
      loaded_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OBJ_BYTES: obj_q      <= cfg_data_i;
          CFG_STRIDE:    stride_q   <= cfg_data_i;
          CFG_SPP:       spp_q      <= cfg_data_i[SPP_W-1:0];
          CFG_CAPACITY:  capacity_q <= cfg_data_i;
          CFG_SLABS:     slabs_q    <= cfg_data_i[SPP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        kind_q <= kind_e'(in_kind_i);
        idx_q  <= '0;
        unique case (kind_e'(in_kind_i))
          KIND_ALLOC: status_q <= ST_FULL;
          KIND_FREE:  status_q <= ST_NOTPOOL;
          default:    status_q <= ST_OK;
        endcase
      end
      if (cmd_i.eval) begin
        if (kind_q == KIND_LOAD) begin
          if (loaded_q[sel_q]) used_q <= used_q - CNT_W'(held);
          loaded_q[sel_q] <= 1'b1;
        end else if (hit) begin
          if (kind_q == KIND_ALLOC) begin
            used_q   <= used_q + CNT_W'(1);
            status_q <= ST_OK;
          end
        end else begin
          idx_q <= idx_q + SEL_W'(1);
        end
      end
      if (cmd_i.free_fin) begin
        status_q <= free_status;
        if (free_status == ST_OK) used_q <= used_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q    <= in_data_i[ADDR_W-1:0];
      phys_q    <= in_data_i[2*ADDR_W-1:ADDR_W];
      sel_q     <= in_data_i[2*ADDR_W+SEL_W-1:2*ADDR_W];
      va_q      <= '0;
      pa_q      <= '0;
      granted_q <= '0;
    end
    if (cmd_i.eval && (kind_q == KIND_ALLOC) && alloc_hit) begin
      va_q      <= vbase_rd + ADDR_W'(alloc_off);
      pa_q      <= pbase_rd + ADDR_W'(alloc_off);
      granted_q <= obj_q;
    end
    if (cmd_i.div_start) begin
      off_q <= diff[OFF_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_data_q   <= {6'd0, used_q, granted_q, pa_q, va_q};
    end
  end

  always_comb begin
    stat_o.kind        = kind_q;
    stat_o.skip        = (kind_q == KIND_NOP) || ((kind_q == KIND_LOAD) && !sel_ok) ||
                         (((kind_q == KIND_ALLOC) || (kind_q == KIND_FREE)) && (lim == '0));
    stat_o.hit         = hit;
    stat_o.last        = (SPP_W'(idx_q) + SPP_W'(1)) >= lim;
    stat_o.div_done    = div_done;
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.out_pending = out_valid_q;
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

>>> rtl/slab_bitmap_slot_allocator.sv
// One item at a time: no-op, load, allocate over the slabs scanned in turn, and free
// over the slabs scanned followed by a divide (one quotient bit per cycle).
// The next item is taken while the result still waits in the output register.
// Slab metadata lives in two registered-read RAMs.
// Reset (rst_ni low, asynchronous) clears all slabs to unloaded, used count
// to zero and the registers to their defaults.
module slab_bitmap_slot_allocator #(
  parameter int unsigned MAX_SLABS      = sbsa_pkg::MAX_SLABS_DEF,
  parameter int unsigned SLOTS_PER_SLAB = sbsa_pkg::SLOTS_PER_SLAB_DEF,
  parameter int unsigned PAGE_BYTES     = sbsa_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbsa_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [sbsa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // address[47:0], phys_page[95:48], slab_select[101:96], zero pad
  input  logic [sbsa_pkg::IN_DW-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [sbsa_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // virt_addr[47:0], phys_addr[95:48], granted_bytes[108:96], objects_used[121:109]
  output logic [sbsa_pkg::OUT_DW-1:0]   m_axis_tdata,
  // status[2:0]
  output logic [sbsa_pkg::STAT_W-1:0]   m_axis_tuser
);
  import sbsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sbsa_dp #(
    .MAX_SLABS      (MAX_SLABS),
    .SLOTS_PER_SLAB (SLOTS_PER_SLAB),
    .PAGE_BYTES     (PAGE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
